>>> src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is applied.
`define CSPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cspd assertion failed");

// Clocked check that also holds during reset.
`define CSPD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cspd assertion failed");

`else

`define CSPD_ASSERT(lbl, clk, rst_n, prop)
`define CSPD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> src/cspd_pkg.sv
package cspd_pkg;

  localparam int MAX_BODY = 254;
  localparam logic [7:0] CODE_NO_ZERO = 8'hFF;
  localparam logic [7:0] MAX_PAYLOAD_RST = 8'd250;

  // Result queue between decoder and output stage.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_TOO_BIG  = 2'd2;
  localparam logic [1:0] ST_SHORT    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TYPE_MASK   = 2'd0;
  localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd1;
  localparam logic [1:0] CFG_SWAP_TYPE   = 2'd2;

  typedef struct packed {
    logic [31:0] type_mask;
    logic [7:0]  max_payload;
    logic        swap_type;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        last;
    logic [1:0]  status;
    logic [31:0] pkt_type;
  } res_t;

  function automatic logic [31:0] byte_reverse(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

>>> src/cspd_front.sv
module cspd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  cspd_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_rx_byte,
  input  logic           q_full,
  output logic           q_push,
  output cspd_pkg::res_t q_data
);
  import cspd_pkg::*;

  logic [8:0]  body_count_r, body_count_nxt;
  logic [7:0]  grp_rem_r, grp_rem_nxt;
  logic [7:0]  grp_code_r, grp_code_nxt;
  logic [8:0]  dec_idx_r, dec_idx_nxt;
  logic [31:0] type_word_r, type_word_nxt;
  logic [7:0]  held_byte_r, held_byte_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic        ovf_r, ovf_nxt;

  logic        acc;
  logic        have;
  logic [7:0]  dec;
  logic [8:0]  bc_inc;
  logic        type_hit;
  logic        tm_cur;
  logic [31:0] tw;

  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall;
  assign bc_inc   = body_count_r + 9'd1;
  assign type_hit = |(type_word_r & cfg.type_mask);
  assign tm_cur   = (dec_idx_r >= 9'd4) && type_hit;

  always_comb begin
    body_count_nxt = body_count_r;
    grp_rem_nxt    = grp_rem_r;
    grp_code_nxt   = grp_code_r;
    dec_idx_nxt    = dec_idx_r;
    type_word_nxt  = type_word_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    ovf_nxt        = ovf_r;
    q_push         = 1'b0;
    q_data         = '0;
    have           = 1'b0;
    dec            = '0;
    tw             = '0;
    if (acc) begin
      if (in_rx_byte == 8'd0) begin
        // End of packet: report, then clear packet state.
        if (body_count_r != 9'd0) begin
          if (ovf_r) begin
            if (tm_cur) begin
              q_push = 1'b1;
              q_data = '{8'd0, 1'b0, 1'b1, ST_TOO_LONG, type_word_r};
            end
          end else if (dec_idx_r < 9'd4) begin
            q_push = 1'b1;
            q_data = '{8'd0, 1'b0, 1'b1, ST_SHORT, 32'd0};
          end else if (tm_cur) begin
            q_push = 1'b1;
            if ((dec_idx_r - 9'd4) > {1'b0, cfg.max_payload}) begin
              q_data = '{8'd0, 1'b0, 1'b1, ST_TOO_BIG, type_word_r};
            end else if (held_valid_r) begin
              q_data = '{held_byte_r, 1'b1, 1'b1, ST_OK, type_word_r};
            end else begin
              q_data = '{8'd0, 1'b0, 1'b1, ST_OK, type_word_r};
            end
          end
        end
        body_count_nxt = '0;
        grp_rem_nxt    = '0;
        grp_code_nxt   = '0;
        dec_idx_nxt    = '0;
        type_word_nxt  = '0;
        held_byte_nxt  = '0;
        held_valid_nxt = 1'b0;
        ovf_nxt        = 1'b0;
      end else if (!ovf_r) begin
        body_count_nxt = bc_inc;
        if (bc_inc > 9'(MAX_BODY)) begin
          // Body too long: flush held byte, drop the rest of the body.
          ovf_nxt = 1'b1;
          if (held_valid_r && tm_cur) begin
            q_push = 1'b1;
            q_data = '{held_byte_r, 1'b1, 1'b0, ST_OK, type_word_r};
          end
          held_valid_nxt = 1'b0;
        end else begin
          if (body_count_r == 9'd0) begin
            grp_code_nxt = in_rx_byte;
            grp_rem_nxt  = in_rx_byte - 8'd1;
          end else if (grp_rem_r != 8'd0) begin
            dec         = in_rx_byte;
            have        = 1'b1;
            grp_rem_nxt = grp_rem_r - 8'd1;
          end else begin
            // New group: the old one ends in an implied zero unless code was 0xFF.
            if (grp_code_r < CODE_NO_ZERO) begin
              have = 1'b1;
            end
            grp_code_nxt = in_rx_byte;
            grp_rem_nxt  = in_rx_byte - 8'd1;
          end

          if (have) begin
            dec_idx_nxt = dec_idx_r + 9'd1;
            if (dec_idx_r < 9'd4) begin
              tw = type_word_r | ({24'd0, dec} << {dec_idx_r[1:0], 3'b000});
              if (dec_idx_r[1:0] == 2'd3 && cfg.swap_type) begin
                tw = byte_reverse(tw);
              end
              type_word_nxt = tw;
            end else if (type_hit) begin
              if ((dec_idx_r - 9'd3) > {1'b0, cfg.max_payload}) begin
                if (held_valid_r) begin
                  q_push = 1'b1;
                  q_data = '{held_byte_r, 1'b1, 1'b0, ST_OK, type_word_r};
                end
                held_valid_nxt = 1'b0;
              end else begin
                if (held_valid_r) begin
                  q_push = 1'b1;
                  q_data = '{held_byte_r, 1'b1, 1'b0, ST_OK, type_word_r};
                end
                held_byte_nxt  = dec;
                held_valid_nxt = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_count_r <= '0;
      grp_rem_r    <= '0;
      grp_code_r   <= '0;
      dec_idx_r    <= '0;
      type_word_r  <= '0;
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
      ovf_r        <= 1'b0;
    end else begin
      body_count_r <= body_count_nxt;
      grp_rem_r    <= grp_rem_nxt;
      grp_code_r   <= grp_code_nxt;
      dec_idx_r    <= dec_idx_nxt;
      type_word_r  <= type_word_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

endmodule

>>> src/cspd_queue.sv
module cspd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cspd_pkg::res_t push_data,
  input  logic           pop,
  output cspd_pkg::res_t pop_data,
  output logic           empty,
  output logic           full
);
  import cspd_pkg::*;

  res_t              entries_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign pop_data = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/cspd_back.sv
module cspd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  cspd_pkg::res_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output cspd_pkg::res_t out_res
);
  import cspd_pkg::*;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  // Load when the register is free or being taken this cycle.
  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_res_r <= q_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> src/cobs_signal_packet_decoder_top.sv
// COBS signal-stream packet decoder.
// Input channel (in_valid / in_stall / in_rx_byte): one raw stream byte per
// item; a zero byte ends a packet. The block takes one byte every cycle as
// long as its result queue has room; in_stall rises only when the two-entry
// queue is full because the output side is stalled.
// Output channel (out_valid / out_stall / out_*): payload bytes of packets
// whose type word ANDed with type_mask is nonzero, then a final item with
// out_last set and a status (ok, body too long, payload too big, too short);
// a too-short packet gets its final item whatever the mask. Each payload byte
// is held back until the next decoded byte or the packet end, so the final
// item can carry the last byte. A result goes from the decoder into the queue
// and then into the output register (decoder -> queue -> output register).
// Throughput: one byte per cycle while in_stall is low.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): always
// ready; index 0 type_mask, 1 max_payload, 2 swap_type. Write only while idle.
// Reset (rst_n low, synchronous): clears packet state and the queue, empties
// the output register, mask 0, max_payload 250, no swap.
// While out_stall is high the output item holds; the queue absorbs results
// until full, then in_stall pushes back on the input.
`include "assert_macros.svh"

module cobs_signal_packet_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_valid,
  output logic        out_last,
  output logic [1:0]  out_status,
  output logic [31:0] out_pkt_type,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import cspd_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic q_push, q_pop, q_empty, q_full;
  res_t q_in, q_out, out_res;

  // Configuration registers, always ready.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TYPE_MASK:   cfg_nxt.type_mask   = cfg_data;
        CFG_MAX_PAYLOAD: cfg_nxt.max_payload = cfg_data[7:0];
        CFG_SWAP_TYPE:   cfg_nxt.swap_type   = cfg_data[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.type_mask   <= '0;
      cfg_r.max_payload <= MAX_PAYLOAD_RST;
      cfg_r.swap_type   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: COBS decode, type match, payload hold-back and packet status.
  cspd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  // Queue decouples the decoder from output back-pressure.
  cspd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Back: output register toward the receiver.
  cspd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_payload_byte  = out_res.payload_byte;
  assign out_payload_valid = out_res.payload_valid;
  assign out_last          = out_res.last;
  assign out_status        = out_res.status;
  assign out_pkt_type      = out_res.pkt_type;

  // Never push into a full queue: input stall must cover it.
  `CSPD_ASSERT(a_no_q_overflow, clk, rst_n, q_full |-> !q_push)
  // Never pop an empty queue.
  `CSPD_ASSERT(a_no_q_underflow, clk, rst_n, q_empty |-> !q_pop)
  // An error status appears only on the final item of a packet.
  `CSPD_ASSERT(a_err_on_last, clk, rst_n,
    (out_valid && out_status != ST_OK) |-> (out_last && !out_payload_valid))

endmodule

>>> bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cspd_pkg::*;

  // Spare register index: no register behind it, writes must be ignored.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  localparam int DIR_ROWS      = 25;
  localparam int SETTLE_CYCLES = 8;     // longer than the path through queue and output register
  localparam int HOLD_AT       = 60;    // result count that triggers the long hold-off
  localparam int HOLD_CYCLES   = 200;
  localparam int WATCHDOG_MAX  = 2000;  // cycles without any handshake
  localparam int NUM_PHASES    = 5;
  localparam int PHASE_ITEMS [NUM_PHASES] = '{290, 260, 250, 265, 60};

  typedef enum {PK_GOOD, PK_SHORT, PK_NOISE, PK_BROKEN, PK_LONG} pkt_kind_t;

  // One stream byte, optionally with a hand-written expectation attached.
  typedef struct packed {
    logic [7:0] rx;
    logic       fixed;
    res_t       want;
  } stim_row_t;

  localparam res_t NO_RES = '0;

  // Directed packets, written against mask 8000_0001, max_payload 2, no swap.
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    // empty packet: a lone terminator gives nothing
    {8'h00, 1'b0, NO_RES},
    // too short: one decoded byte, status-only with a zero type
    {8'h02, 1'b0, NO_RES},
    {8'hAA, 1'b0, NO_RES},
    {8'h00, 1'b1, 8'h00, 1'b0, 1'b1, ST_SHORT, 32'h0000_0000},
    // type word alone, bit 31 hits the mask: empty payload, status ok
    {8'h05, 1'b0, NO_RES},
    {8'h11, 1'b0, NO_RES},
    {8'h22, 1'b0, NO_RES},
    {8'h33, 1'b0, NO_RES},
    {8'h80, 1'b0, NO_RES},
    {8'h00, 1'b1, 8'h00, 1'b0, 1'b1, ST_OK, 32'h8033_2211},
    // type misses the mask: the packet vanishes
    {8'h05, 1'b0, NO_RES},
    {8'h02, 1'b0, NO_RES},
    {8'h02, 1'b0, NO_RES},
    {8'h02, 1'b0, NO_RES},
    {8'h02, 1'b0, NO_RES},
    {8'h00, 1'b0, NO_RES},
    // code promises eight bytes, body stops at seven (truncated group);
    // third payload byte exceeds max_payload: two bytes flushed, then too big
    {8'h09, 1'b0, NO_RES},
    {8'h01, 1'b0, NO_RES},
    {8'h01, 1'b0, NO_RES},
    {8'h01, 1'b0, NO_RES},
    {8'h01, 1'b0, NO_RES},
    {8'hFF, 1'b0, NO_RES},
    {8'h7E, 1'b0, NO_RES},
    {8'hA3, 1'b0, NO_RES},
    {8'h00, 1'b1, 8'h00, 1'b0, 1'b1, ST_TOO_BIG, 32'h0101_0101}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_payload_byte;
  logic        out_payload_valid;
  logic        out_last;
  logic [1:0]  out_status;
  logic [31:0] out_pkt_type;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  cobs_signal_packet_decoder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_payload_valid(out_payload_valid),
    .out_last         (out_last),
    .out_status       (out_status),
    .out_pkt_type     (out_pkt_type),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Decoder prediction: own copy of the registers and the packet state.
  // ---------------------------------------------------------------------
  logic [31:0] cfg_mask;
  logic [7:0]  cfg_max_pl;
  logic        cfg_swap;

  logic [8:0]  body_cnt;     // body bytes seen, stops one past MAX_BODY
  logic [7:0]  grp_left;     // data bytes still owed by the current code
  logic [7:0]  grp_code;
  logic [8:0]  dec_cnt;      // decoded bytes so far
  logic [31:0] type_acc;
  logic [7:0]  held_b;       // payload byte held back for the last flag
  logic        held_v;
  logic        body_over;

  res_t        packet_results_q [$];   // decoder results still to come out
  stim_row_t   stim_plan [$];          // bytes of the current phase

  int          errors = 0;
  int          results_seen = 0;
  int          tx_run = 0;
  bit          tx_calm = 0;
  int          rx_run = 0;
  bit          rx_calm = 0;
  int          quiet = 0;

  function automatic void clear_packet_state();
    body_cnt  = '0;
    grp_left  = '0;
    grp_code  = '0;
    dec_cnt   = '0;
    type_acc  = '0;
    held_b    = '0;
    held_v    = 1'b0;
    body_over = 1'b0;
  endfunction

  function automatic bit type_passes();
    return dec_cnt >= 9'd4 && (type_acc & cfg_mask) != 32'h0;
  endfunction

  function automatic res_t mk_res(input logic [7:0] d, input logic v, input logic l,
                                  input logic [1:0] s, input logic [31:0] t);
    res_t x;
    x.payload_byte  = d;
    x.payload_valid = v;
    x.last          = l;
    x.status        = s;
    x.pkt_type      = t;
    return x;
  endfunction

  // Advance the packet state by one stream byte; return 1 when it yields a result.
  function automatic bit decode_rx_byte(input logic [7:0] b, output res_t r);
    logic [7:0] dec;
    bit         have;
    bit         hit;
    logic [8:0] idx;
    dec  = '0;
    have = 1'b0;
    hit  = 1'b0;
    r    = NO_RES;

    // Terminator: close the packet.
    if (b == 8'h00) begin
      if (body_cnt == '0) begin
        hit = 1'b0;
      end else if (body_over) begin
        if (type_passes()) begin
          r   = mk_res(8'h00, 1'b0, 1'b1, ST_TOO_LONG, type_acc);
          hit = 1'b1;
        end
      end else if (dec_cnt < 9'd4) begin
        r   = mk_res(8'h00, 1'b0, 1'b1, ST_SHORT, 32'h0);
        hit = 1'b1;
      end else if (type_passes()) begin
        hit = 1'b1;
        if (int'(dec_cnt) - 4 > int'(cfg_max_pl))
          r = mk_res(8'h00, 1'b0, 1'b1, ST_TOO_BIG, type_acc);
        else if (held_v)
          r = mk_res(held_b, 1'b1, 1'b1, ST_OK, type_acc);
        else
          r = mk_res(8'h00, 1'b0, 1'b1, ST_OK, type_acc);
      end
      clear_packet_state();
      return hit;
    end

    if (body_over) return 1'b0;

    body_cnt++;
    if (body_cnt > MAX_BODY) begin
      body_over = 1'b1;
      if (held_v && type_passes()) begin
        r   = mk_res(held_b, 1'b1, 1'b0, ST_OK, type_acc);
        hit = 1'b1;
      end
      held_v = 1'b0;
      return hit;
    end

    // COBS: code byte, its data bytes, then an implied zero unless code is FF.
    if (body_cnt == 9'd1) begin
      grp_code = b;
      grp_left = b - 8'd1;
    end else if (grp_left != '0) begin
      dec  = b;
      have = 1'b1;
      grp_left--;
    end else begin
      if (grp_code != CODE_NO_ZERO) begin
        dec  = 8'h00;
        have = 1'b1;
      end
      grp_code = b;
      grp_left = b - 8'd1;
    end

    if (!have) return 1'b0;

    idx = dec_cnt;
    dec_cnt++;

    if (idx < 9'd4) begin
      type_acc = type_acc | (32'(dec) << (8 * idx));
      if (idx == 9'd3 && cfg_swap)
        type_acc = {type_acc[7:0], type_acc[15:8], type_acc[23:16], type_acc[31:24]};
      return 1'b0;
    end

    if (!type_passes()) return 1'b0;

    if (int'(idx) - 3 > int'(cfg_max_pl)) begin
      if (held_v) begin
        r   = mk_res(held_b, 1'b1, 1'b0, ST_OK, type_acc);
        hit = 1'b1;
      end
      held_v = 1'b0;
      return hit;
    end

    if (held_v) begin
      r      = mk_res(held_b, 1'b1, 1'b0, ST_OK, type_acc);
      held_b = dec;
      return 1'b1;
    end
    held_b = dec;
    held_v = 1'b1;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus shaping.
  // ---------------------------------------------------------------------

  // Idle length for one item; alternate between busy stretches and
  // stretches that run at full rate.
  function automatic int draw_gap(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      calm     = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(20, 80);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [7:0] rand_payload_byte();
    return ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom());
  endfunction

  task automatic add_rx(input logic [7:0] b);
    stim_row_t row;
    row.rx    = b;
    row.fixed = 1'b0;
    row.want  = NO_RES;
    stim_plan.push_back(row);
  endtask

  // Queue one packet of the given kind, terminator included.
  task automatic add_packet(input pkt_kind_t kind);
    logic [7:0]  dec [$];
    logic [7:0]  enc [$];
    logic [31:0] t;
    logic [31:0] raw;
    int          n;
    int          cut;
    int          code_pos;
    int          run;

    if (kind == PK_NOISE) begin
      // Raw junk: arbitrary codes, truncated groups, sometimes an empty packet.
      n = $urandom_range(0, 14);
      repeat (n) add_rx(8'($urandom_range(1, 255)));
      add_rx(8'h00);
      return;
    end

    if (kind == PK_SHORT) begin
      n = $urandom_range(0, 3);
      repeat (n) dec.push_back(rand_payload_byte());
    end else begin
      t = $urandom();
      if ($urandom_range(0, 4) == 0)
        t = t & ~cfg_mask;                          // force a miss
      else if ((t & cfg_mask) == 32'h0 && cfg_mask != 32'h0)
        t = t | (cfg_mask & (~cfg_mask + 32'd1));   // force a hit on the lowest mask bit
      raw = cfg_swap ? {t[7:0], t[15:8], t[23:16], t[31:24]} : t;
      for (int i = 0; i < 4; i++) dec.push_back(raw[8*i +: 8]);

      if (kind == PK_LONG) begin
        n = $urandom_range(252, 262);
      end else if (cfg_max_pl <= 8'd40 && $urandom_range(0, 5) == 0) begin
        // land right around the payload limit
        n = int'(cfg_max_pl) + int'($urandom_range(0, 2)) - 1;
        if (n < 0) n = 0;
      end else if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(13, 40);
      end else begin
        n = $urandom_range(0, 12);
      end
      repeat (n) dec.push_back(rand_payload_byte());
    end

    // COBS encode: patch each code byte once its group closes.
    enc.push_back(8'h01);
    code_pos = 0;
    run      = 0;
    foreach (dec[i]) begin
      if (dec[i] == 8'h00) begin
        enc[code_pos] = 8'(run + 1);
        enc.push_back(8'h01);
        code_pos = enc.size() - 1;
        run      = 0;
      end else begin
        enc.push_back(dec[i]);
        run++;
        if (run == 254) begin
          enc[code_pos] = CODE_NO_ZERO;
          enc.push_back(8'h01);
          code_pos = enc.size() - 1;
          run      = 0;
        end
      end
    end
    enc[code_pos] = 8'(run + 1);

    // Broken packets lose their tail before the terminator.
    cut = (kind == PK_BROKEN) ? $urandom_range(1, enc.size()) : enc.size();
    for (int i = 0; i < cut; i++) add_rx(enc[i]);
    add_rx(8'h00);
  endtask

  // ---------------------------------------------------------------------
  // Channel drivers.
  // ---------------------------------------------------------------------

  // Write one register and mirror it into the predictor on the handshake.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TYPE_MASK:   cfg_mask   = val;
      CFG_MAX_PAYLOAD: cfg_max_pl = val[7:0];
      CFG_SWAP_TYPE:   cfg_swap   = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Program all three registers; fill unused data bits with noise.
  task automatic set_regs(input logic [31:0] mask, input logic [7:0] max_pl,
                          input logic swap);
    write_reg(CFG_TYPE_MASK, mask);
    write_reg(CFG_MAX_PAYLOAD, ($urandom() & 32'hFFFF_FF00) | 32'(max_pl));
    write_reg(CFG_SWAP_TYPE, ($urandom() & 32'hFFFF_FFFE) | 32'(swap));
  endtask

  // Offer every planned byte in order; predict on each accepted item.
  task automatic send_plan();
    res_t r;
    bit   hit;
    int   gap;
    foreach (stim_plan[i]) begin
      gap = draw_gap(tx_run, tx_calm);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid   <= 1'b1;
      in_rx_byte <= stim_plan[i].rx;
      do @(posedge clk); while (in_stall);
      hit = decode_rx_byte(stim_plan[i].rx, r);
      // a typed-in expectation overrides the prediction for that row
      if (stim_plan[i].fixed)
        packet_results_q.push_back(stim_plan[i].want);
      else if (hit)
        packet_results_q.push_back(r);
      @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // Drain: wait for every expected item, then let trailing bytes clear the pipe.
  task automatic settle();
    while (packet_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stall, one long hold-off, field-by-field check.
  // ---------------------------------------------------------------------
  initial begin
    res_t want;
    int   gap;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      // Hold off once for a long stretch while the sender keeps pushing,
      // so the result queue fills and the input gets stalled.
      if (results_seen == HOLD_AT)
        gap = HOLD_CYCLES;
      else
        gap = draw_gap(rx_run, rx_calm);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (packet_results_q.size() == 0) begin
        $error("result with nothing expected: byte %h last %b status %0d type %h",
               out_payload_byte, out_last, out_status, out_pkt_type);
        errors++;
      end else begin
        want = packet_results_q.pop_front();
        if (out_payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %h, got %h", want.payload_byte, out_payload_byte);
          errors++;
        end
        if (out_payload_valid !== want.payload_valid) begin
          $error("payload_valid: expected %b, got %b", want.payload_valid, out_payload_valid);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_last);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_pkt_type !== want.pkt_type) begin
          $error("pkt_type: expected %h, got %h", want.pkt_type, out_pkt_type);
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog: count cycles in which no channel moves anything.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_MAX) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence: reset, directed table, then randomized phases.
  // ---------------------------------------------------------------------
  initial begin
    pkt_kind_t kind;
    int        pick;

    // Drive every input to a known value before the first edge.
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    out_stall  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_TYPE_MASK;
    cfg_data   = 32'h0;

    // Predictor starts from the reset register values.
    cfg_mask   = 32'h0;
    cfg_max_pl = MAX_PAYLOAD_RST;
    cfg_swap   = 1'b0;
    clear_packet_state();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: hand-picked packets against a narrow mask and a tiny
    // payload limit.
    set_regs(32'h8000_0001, 8'd2, 1'b0);
    stim_plan.delete();
    foreach (DIR_TABLE[i]) stim_plan.push_back(DIR_TABLE[i]);
    send_plan();
    settle();

    // Randomized phases: each one reprograms the block while it is idle,
    // then streams mostly well-formed packets with some junk mixed in.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_regs(32'hFFFF_FFFF, 8'd250, 1'b1);          // everything passes
        1: begin
          set_regs($urandom(), 8'd0, 1'b0);                 // zero payload allowed
          write_reg(CFG_SPARE, $urandom());                 // must change nothing
        end
        2: set_regs(32'h1 << $urandom_range(0, 31), 8'($urandom_range(0, 250)),
                    1'($urandom_range(0, 1)));
        3: set_regs($urandom(), 8'($urandom_range(1, 8)), 1'b1);
        default: set_regs(32'h0, 8'd250, 1'b0);             // nothing passes
      endcase

      stim_plan.delete();
      // Overlong body in two phases: saturate the body counter.
      if (ph == 0 || ph == 3) add_packet(PK_LONG);
      while (stim_plan.size() < PHASE_ITEMS[ph]) begin
        pick = $urandom_range(0, 19);
        if (pick < 14)      kind = PK_GOOD;
        else if (pick < 16) kind = PK_SHORT;
        else if (pick < 19) kind = PK_NOISE;
        else                kind = PK_BROKEN;
        add_packet(kind);
      end
      send_plan();
      settle();
    end

    if (packet_results_q.size() != 0) begin
      $error("%0d expected results never arrived", packet_results_q.size());
      errors++;
    end
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
